// ===== rtl/rtsm_pkg.sv =====
// Package for the ray terrain shadow marker: widths, codes and shared types.
package rtsm_pkg;

  localparam int unsigned MAP_SIZE  = 1024;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned MARGIN_W  = 15;
  localparam int unsigned ERR_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 15;

  localparam logic [COORD_W-1:0]  CoordMax     = COORD_W'(MAP_SIZE - 1);
  localparam logic [MARGIN_W-1:0] MarginReset  = MARGIN_W'(715);

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_CELL  = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_MARGIN   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic                      action;
    logic [COORD_W-1:0]        end_x;
    logic [COORD_W-1:0]        end_y;
    logic signed [ANGLE_W-1:0] elevation;
    logic                      out_of_range;
  } in_item_t;

  typedef struct packed {
    logic               judged;
    logic               shadow;
    logic [COORD_W-1:0] next_x;
    logic [COORD_W-1:0] next_y;
    logic               ray_done;
  } out_item_t;

  function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v);
    return (v > CoordMax) ? CoordMax : v;
  endfunction

endpackage

// ===== rtl/rtsm_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface rtsm_in_if
  import rtsm_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [COORD_W-1:0]        end_x;
  logic [COORD_W-1:0]        end_y;
  logic signed [ANGLE_W-1:0] elevation;
  logic                      out_of_range;

  modport source (output valid, action, end_x, end_y, elevation, out_of_range, input ready);
  modport sink   (input valid, action, end_x, end_y, elevation, out_of_range, output ready);
endinterface

interface rtsm_out_if
  import rtsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               judged;
  logic               shadow;
  logic [COORD_W-1:0] next_x;
  logic [COORD_W-1:0] next_y;
  logic               ray_done;

  modport source (output valid, judged, shadow, next_x, next_y, ray_done, input ready);
  modport sink   (input valid, judged, shadow, next_x, next_y, ray_done, output ready);
endinterface

// ===== rtl/rtsm_core.sv =====
// Ray state, config registers and the per-item Bresenham step and shadow compare.
module rtsm_core
  import rtsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_wr_t   cfg_i,
  input  logic      fire_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  logic [COORD_W-1:0]        origin_x_q, origin_y_q;
  logic [MARGIN_W-1:0]       margin_q;

  logic [COORD_W-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_W-1:0]        tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_W-1:0]        dist_x_q, dist_x_d, dist_y_q, dist_y_d;
  logic                      dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [ANGLE_W-1:0] hmax_q, hmax_d;
  logic                      have_h_q, have_h_d;
  logic                      axis_q, axis_d;
  logic                      active_q, active_d;

  logic [COORD_W-1:0]        ox, oy, tx, ty, dx, dy;
  logic                      xneg, yneg;
  logic signed [ANGLE_W+1:0] thresh, el_ext;
  logic signed [ERR_W-1:0]   dx_s, dy_s, err_a;
  logic                      shadow;

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    dist_x_d    = dist_x_q;
    dist_y_d    = dist_y_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    err_d       = err_q;
    hmax_d      = hmax_q;
    have_h_d    = have_h_q;
    axis_d      = axis_q;
    active_d    = active_q;
    res_o       = '{judged: 1'b0, shadow: 1'b0, next_x: '0, next_y: '0, ray_done: 1'b1};

    ox   = clamp_coord(origin_x_q);
    oy   = clamp_coord(origin_y_q);
    tx   = clamp_coord(item_i.end_x);
    ty   = clamp_coord(item_i.end_y);
    xneg = tx < ox;
    yneg = ty < oy;
    dx   = xneg ? (ox - tx) : (tx - ox);
    dy   = yneg ? (oy - ty) : (ty - oy);

    // exact signed compare, two guard bits
    thresh = $signed({{2{hmax_q[ANGLE_W-1]}}, hmax_q}) - $signed({3'b000, margin_q});
    el_ext = $signed({{2{item_i.elevation[ANGLE_W-1]}}, item_i.elevation});
    shadow = have_h_q && (thresh > el_ext);

    dx_s  = $signed({{(ERR_W-COORD_W){1'b0}}, dist_x_q});
    dy_s  = $signed({{(ERR_W-COORD_W){1'b0}}, dist_y_q});
    err_a = err_q;

    if (item_i.action == ACT_START) begin
      cur_x_d     = ox;
      cur_y_d     = oy;
      tgt_x_d     = tx;
      tgt_y_d     = ty;
      dir_x_neg_d = xneg;
      dir_y_neg_d = yneg;
      dist_x_d    = dx;
      dist_y_d    = dy;
      err_d       = (dx > dy) ? $signed({{(ERR_W-COORD_W+1){1'b0}}, dx[COORD_W-1:1]})
                              : -$signed({{(ERR_W-COORD_W+1){1'b0}}, dy[COORD_W-1:1]});
      axis_d      = (dx == '0) || (dy == '0);
      have_h_d    = 1'b0;
      hmax_d      = '0;
      active_d    = 1'b1;
      res_o       = '{judged: 1'b0, shadow: 1'b0, next_x: ox, next_y: oy, ray_done: 1'b0};
    end else if (!active_q) begin
      // idle: default result
    end else if (have_h_q && !axis_q && item_i.out_of_range) begin
      // stepped cell beyond range ends a diagonal ray unjudged
      active_d = 1'b0;
    end else begin
      if (!have_h_q || (item_i.elevation > hmax_q)) hmax_d = item_i.elevation;
      have_h_d = 1'b1;
      if ((cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q)) begin
        active_d = 1'b0;
        res_o    = '{judged: 1'b1, shadow: shadow, next_x: '0, next_y: '0, ray_done: 1'b1};
      end else begin
        if (err_q > -dx_s) begin
          err_a   = err_a - dy_s;
          cur_x_d = dir_x_neg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
        end
        if (err_q < dy_s) begin
          err_a   = err_a + dx_s;
          cur_y_d = dir_y_neg_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
        end
        err_d = err_a;
        res_o = '{judged: 1'b1, shadow: shadow, next_x: cur_x_d, next_y: cur_y_d,
                  ray_done: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      margin_q   <= MarginReset;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_ORIGIN_X: origin_x_q <= cfg_i.wdata[COORD_W-1:0];
        CFG_ORIGIN_Y: origin_y_q <= cfg_i.wdata[COORD_W-1:0];
        CFG_MARGIN:   margin_q   <= cfg_i.wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      dist_x_q    <= '0;
      dist_y_q    <= '0;
      dir_x_neg_q <= 1'b0;
      dir_y_neg_q <= 1'b0;
      err_q       <= '0;
      hmax_q      <= '0;
      have_h_q    <= 1'b0;
      axis_q      <= 1'b0;
      active_q    <= 1'b0;
    end else if (fire_i) begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      dist_x_q    <= dist_x_d;
      dist_y_q    <= dist_y_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      err_q       <= err_d;
      hmax_q      <= hmax_d;
      have_h_q    <= have_h_d;
      axis_q      <= axis_d;
      active_q    <= active_d;
    end
  end

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(active_q) && $stable(cur_x_q) && $stable(have_h_q))
    else $error("ray state changed without a processed transaction");

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.action == ACT_START) |=> active_q && !have_h_q)
    else $error("start did not arm a fresh ray");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.ray_done) |=> !active_q)
    else $error("ray reported done but stays active");

endmodule

// ===== rtl/ray_terrain_shadow_marker_unit.sv =====
// Top level: input register, ray core and result register.
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    action, end_x, end_y, elevation, out_of_range
//  out_o    out  valid/ready    judged, shadow, next_x, next_y, ray_done
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i (write only)
//
// One transaction per cycle sustained while out_o does not stall; a result is
// offered once its input transaction has passed the input register and then the
// core step into the result register.
// The core step is one Bresenham update and one 18-bit compare per unstalled cycle.
// Reset clears the ray (idle) and sets the config registers to their defaults.
// A stall on out_o holds the result; an empty input register still takes one more
// transaction before in_i.ready drops.
module ray_terrain_shadow_marker_unit
  import rtsm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  rtsm_in_if.sink              in_i,
  rtsm_out_if.source           out_o
);

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      res_valid_q;
  out_item_t res_q;
  out_item_t core_res;
  cfg_wr_t   cfg;
  logic      adv;
  logic      in_fire;

  assign cfg     = '{we: cfg_we_i, idx: cfg_idx_i, wdata: cfg_wdata_i};
  assign adv     = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{action: in_i.action, end_x: in_i.end_x, end_y: in_i.end_y,
                     elevation: in_i.elevation, out_of_range: in_i.out_of_range};
    end
  end

  rtsm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (adv),
    .item_i (s1_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= core_res;
    end
  end

  assign out_o.valid    = res_valid_q;
  assign out_o.judged   = res_q.judged;
  assign out_o.shadow   = res_q.shadow;
  assign out_o.next_x   = res_q.next_x;
  assign out_o.next_y   = res_q.next_y;
  assign out_o.ray_done = res_q.ray_done;

  a_s1_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted transaction not held in input register");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> s1_valid_q && $stable(s1_item_q))
    else $error("input register lost a pending transaction");

  a_res_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> res_valid_q)
    else $error("processed transaction produced no result");

endmodule

// ===== tb/sv/tb_ray_terrain_shadow_marker_unit.sv =====
`timescale 1ns / 100ps
// Testbench for the ray terrain shadow marker: stimulus, ray prediction and result checking.
module tb_ray_terrain_shadow_marker_unit;
  import rtsm_pkg::*;

  localparam int unsigned CycleLimit = 800000;
  localparam int GapMax = 14;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  rtsm_in_if  in_if ();
  rtsm_out_if out_if ();

  ray_terrain_shadow_marker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted ray state and register copies
  logic [COORD_W-1:0] org_x, org_y;
  int                 margin;
  logic [COORD_W-1:0] ray_x, ray_y, goal_x, goal_y;
  int                 span_x, span_y, bres_err, horizon;
  logic               back_x, back_y, horizon_valid, flat_ray, ray_live;

  out_item_t   expected_verdicts[$];
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int          in_gap_max;
  int          out_gap_max;
  int          rx_hold;

  // Judge one accepted item against the predicted ray and step the line.
  function automatic out_item_t advance_ray(in_item_t it);
    out_item_t r;
    int        el;
    int        e2;
    r = '0;
    if (it.action == ACT_START) begin
      ray_x = org_x;
      ray_y = org_y;
      goal_x = it.end_x;
      goal_y = it.end_y;
      back_x = goal_x < org_x;
      back_y = goal_y < org_y;
      span_x = back_x ? int'(org_x) - int'(goal_x) : int'(goal_x) - int'(org_x);
      span_y = back_y ? int'(org_y) - int'(goal_y) : int'(goal_y) - int'(org_y);
      bres_err = (span_x > span_y) ? span_x / 2 : -(span_y / 2);
      flat_ray = (span_x == 0) || (span_y == 0);
      horizon_valid = 1'b0;
      horizon = 0;
      ray_live = 1'b1;
      r.next_x = ray_x;
      r.next_y = ray_y;
      return r;
    end
    if (!ray_live) begin
      r.ray_done = 1'b1;
      return r;
    end
    el = $signed(it.elevation);
    // marked cell past the origin kills a diagonal ray unjudged
    if (horizon_valid && !flat_ray && it.out_of_range) begin
      ray_live = 1'b0;
      r.ray_done = 1'b1;
      return r;
    end
    if (horizon_valid && (horizon - margin) > el) r.shadow = 1'b1;
    if (!horizon_valid || el > horizon) horizon = el;
    horizon_valid = 1'b1;
    r.judged = 1'b1;
    if (ray_x == goal_x && ray_y == goal_y) begin
      ray_live = 1'b0;
      r.ray_done = 1'b1;
      return r;
    end
    e2 = bres_err;
    if (e2 > -span_x) begin
      bres_err -= span_y;
      ray_x = back_x ? ray_x - 1'b1 : ray_x + 1'b1;
    end
    if (e2 < span_y) begin
      bres_err += span_x;
      ray_y = back_y ? ray_y - 1'b1 : ray_y + 1'b1;
    end
    r.next_x = ray_x;
    r.next_y = ray_y;
    return r;
  endfunction

  function automatic in_item_t start_item(int ex, int ey);
    in_item_t it;
    it.action       = ACT_START;
    it.end_x        = ex[COORD_W-1:0];
    it.end_y        = ey[COORD_W-1:0];
    it.elevation    = ANGLE_W'($urandom);
    it.out_of_range = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t cell_item(logic signed [ANGLE_W-1:0] el, logic oor);
    in_item_t it;
    it.action       = ACT_CELL;
    it.end_x        = COORD_W'($urandom);
    it.end_y        = COORD_W'($urandom);
    it.elevation    = el;
    it.out_of_range = oor;
    return it;
  endfunction

  // Half the time near the shadow threshold so both verdicts show up often.
  function automatic logic signed [ANGLE_W-1:0] pick_elevation();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $signed(ANGLE_W'($urandom));
      3:       v = horizon + int'($urandom_range(0, 400));
      default: v = horizon - margin + int'($urandom_range(0, 64)) - 32;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic int aim_near(logic [COORD_W-1:0] base, int off);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * off)) - off;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  task automatic send_item(in_item_t it);
    int        gap;
    out_item_t verdict;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= it.action;
    in_if.end_x        <= it.end_x;
    in_if.end_y        <= it.end_y;
    in_if.elevation    <= it.elevation;
    in_if.out_of_range <= it.out_of_range;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    verdict = advance_ray(it);
    expected_verdicts = {expected_verdicts, verdict};
    items_sent++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: org_x = val[COORD_W-1:0];
      CFG_ORIGIN_Y: org_y = val[COORD_W-1:0];
      CFG_MARGIN:   margin = int'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(int ox, int oy, int m);
    write_reg(CFG_ORIGIN_X, ox[CFG_DAT_W-1:0]);
    write_reg(CFG_ORIGIN_Y, oy[CFG_DAT_W-1:0]);
    write_reg(CFG_MARGIN, m[CFG_DAT_W-1:0]);
  endtask

  task automatic random_config();
    int m;
    case ($urandom_range(0, 3))
      0:       m = 0;
      1:       m = 32767;
      default: m = $urandom_range(0, 32767);
    endcase
    // origin data above bit 9 is dropped by the register
    set_config($urandom_range(0, 32767), $urandom_range(0, 32767), m);
  endtask

  // Well-formed ray with random content; now and then abandoned midway.
  task automatic run_ray(int max_off);
    send_item(start_item(aim_near(org_x, max_off), aim_near(org_y, max_off)));
    while (ray_live) begin
      if ($urandom_range(0, 59) == 0) break;
      send_item(cell_item(pick_elevation(), $urandom_range(0, 15) == 0));
    end
  endtask

  task automatic apply_reset();
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_ORIGIN_X;
    cfg_wdata_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.action       <= ACT_START;
    in_if.end_x        <= '0;
    in_if.end_y        <= '0;
    in_if.elevation    <= '0;
    in_if.out_of_range <= 1'b0;
    org_x = '0;
    org_y = '0;
    margin = int'(MarginReset);
    ray_x = '0;
    ray_y = '0;
    goal_x = '0;
    goal_y = '0;
    span_x = 0;
    span_y = 0;
    bres_err = 0;
    horizon = 0;
    back_x = 1'b0;
    back_y = 1'b0;
    horizon_valid = 1'b0;
    flat_ray = 1'b0;
    ray_live = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  endtask

  task automatic test_directed();
    send_item(cell_item(16'sh7fff, 1'b1));       // data with no ray
    send_item(start_item(0, 0));                 // single-cell ray
    send_item(cell_item(16'sh8000, 1'b1));
    send_item(start_item(3, 0));                 // axis ray, marks ignored
    send_item(cell_item(16'sh7fff, 1'b0));
    send_item(cell_item(16'sd32051, 1'b0));      // just below threshold
    send_item(cell_item(16'sd32052, 1'b0));      // right at threshold
    send_item(cell_item(16'sh8000, 1'b1));
    send_item(start_item(2, 3));                 // diagonal ray
    send_item(cell_item(16'sd100, 1'b1));        // origin keeps its mark ignored
    send_item(cell_item(-16'sd5, 1'b1));         // ends ray unjudged
    send_item(cell_item(16'sd0, 1'b0));
    send_item(start_item(1023, 1023));
    send_item(cell_item(16'sd0, 1'b0));
    send_item(cell_item(16'sd0, 1'b0));
    send_item(start_item(0, 2));                 // abandons the long ray
    send_item(cell_item(16'sd50, 1'b0));
    send_item(cell_item(-16'sd665, 1'b0));
    send_item(cell_item(-16'sd666, 1'b0));
    send_item(cell_item(16'sd7, 1'b0));
  endtask

  task automatic test_config_sweep();
    for (int k = 0; k < 6; k++) begin
      wait_idle();
      case (k)
        0:       set_config(1023, 1023, 0);
        1:       set_config(1023, 0, 32767);
        2:       set_config(0, 1023, 1);
        3:       set_config(512, 511, int'(MarginReset));
        default: random_config();
      endcase
      repeat (8) run_ray(8);
    end
  endtask

  task automatic test_back_pressure();
    in_gap_max = 0;
    rx_hold = 250;
    repeat (5) run_ray(6);
    in_gap_max = GapMax;
  endtask

  task automatic test_no_idle();
    in_gap_max = 0;
    out_gap_max = 0;
    wait_idle();
    set_config(0, 0, int'(MarginReset));
    send_item(start_item(250, 153));
    while (ray_live) send_item(cell_item(pick_elevation(), 1'b0));
    send_item(start_item(0, 100));
    while (ray_live) send_item(cell_item(pick_elevation(), 1'($urandom)));
    repeat (10) run_ray(5);
    in_gap_max = GapMax;
    out_gap_max = GapMax;
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned next_cfg;
    stop_at = items_sent + 400;
    next_cfg = items_sent + 150;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        wait_idle();
        random_config();
        next_cfg += 150;
      end
      case ($urandom_range(0, 9))
        0: send_item(cell_item(ANGLE_W'($urandom), 1'($urandom)));
        1: begin
          send_item(start_item($urandom_range(0, 1023), $urandom_range(0, 1023)));
          repeat ($urandom_range(0, 4))
            if (ray_live) send_item(cell_item(pick_elevation(), 1'($urandom)));
        end
        default: run_ray(($urandom_range(0, 9) == 0) ? 40 : 6);
      endcase
    end
  endtask

  // Result sink with random stalls and an occasional long hold-off.
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end else begin
        stall = $urandom_range(0, out_gap_max);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.judged   = out_if.judged;
      got.shadow   = out_if.shadow;
      got.next_x   = out_if.next_x;
      got.next_y   = out_if.next_y;
      got.ray_done = out_if.ray_done;
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: judged=%0b shadow=%0b next=(%0d,%0d) done=%0b",
                   got.judged, got.shadow, got.next_x, got.next_y, got.ray_done);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.judged !== want.judged || got.shadow !== want.shadow ||
            got.next_x !== want.next_x || got.next_y !== want.next_y ||
            got.ray_done !== want.ray_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp judged=%0b shadow=%0b next=(%0d,%0d) done=%0b / %s",
                     want.judged, want.shadow, want.next_x, want.next_y, want.ray_done,
                     $sformatf("got judged=%0b shadow=%0b next=(%0d,%0d) done=%0b",
                               got.judged, got.shadow, got.next_x, got.next_y,
                               got.ray_done));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    mismatch_count = 0;
    items_sent = 0;
    in_gap_max = GapMax;
    out_gap_max = GapMax;
    rx_hold = 0;
    apply_reset();
    test_directed();
    test_config_sweep();
    test_back_pressure();
    test_no_idle();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
